// File: src/tpa_pkg.sv
package tpa_pkg;

  // Result status codes carried on result_status.
  typedef enum logic [1:0] {
    ST_TRIANGLE = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_COUNT    = 2'd3
  } status_t;

  // Primitive modes. The unused code behaves as a list.
  localparam logic [1:0] MODE_LIST  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;

  // Register word indexes on the configuration port.
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_FLIP  = 2'd1;
  localparam logic [1:0] REG_BASE  = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  // Corner and register data width.
  localparam int unsigned VTX_W = 32;

  // Corner counter values.
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

endpackage

// File: src/triangle_primitive_assembler.sv
// Triangle primitive assembler.
// The input channel (in_valid/in_ready) takes one vertex index word per cycle
// while in_ready is high, with last_index marking the final word of a
// primitive. The output channel (out_valid/out_ready) gives at most one word
// per input word: a triangle of three global corner indices, or an error
// status with all corners zero. Registers are written over the APB-style port
// at byte addresses 0, 4, 8 and 12 (mode, winding flip, vertex base, vertex
// limit); the user must write them only while the block is idle, which the
// block does not enforce. prdata returns the addressed register. A result is
// loaded into the output register at the edge that accepts its word and is
// offered from the next cycle. Throughput is one word per cycle while the
// receiver takes each word, set by the single output register, which is loaded
// whenever it is empty or being taken. When the receiver stalls, the output
// register holds its word and in_ready drops until that word is taken; a word
// that produces no result still waits behind a held output. Reset clears the
// configuration registers, out_valid and primitive state: mode list, no flip,
// base zero and limit zero, so every index is out of range until written.
module triangle_primitive_assembler
  import tpa_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Index input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VTX_W-1:0]  index_value,
  input  logic              last_index,
  // Triangle output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VTX_W-1:0]  corner_first,
  output logic [VTX_W-1:0]  corner_second,
  output logic [VTX_W-1:0]  corner_third,
  output logic [1:0]        result_status
);

  // Configuration registers.
  logic [1:0]       primitive_mode;
  logic             winding_swap;
  logic [VTX_W-1:0] base_offset;
  logic [VTX_W-1:0] vertex_limit;

  // Primitive state.
  logic [VTX_W-1:0] held_older, held_older_next;
  logic [VTX_W-1:0] held_newer, held_newer_next;
  logic [1:0]       list_phase, list_phase_next;
  logic [1:0]       seen_count, seen_count_next;
  logic             strip_parity, strip_parity_next;
  logic             aborted, aborted_next;

  // Result produced by the current word.
  logic             res_valid;
  logic [VTX_W-1:0] res_a, res_b, res_c;
  status_t          res_status;

  logic             accept;
  logic             cfg_write;
  logic [VTX_W-1:0] local_index;
  logic [VTX_W:0]   sum;
  logic             out_of_range;
  logic             strip_or_fan;
  logic [1:0]       count;
  logic [VTX_W-1:0] tri_a, tri_b, tri_c;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign in_ready  = ~out_valid | out_ready;
  assign accept    = in_valid & in_ready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      primitive_mode <= MODE_LIST;
      winding_swap   <= 1'b0;
      base_offset    <= '0;
      vertex_limit   <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_MODE:  primitive_mode <= pwdata[1:0];
        REG_FLIP:  winding_swap   <= pwdata[0];
        REG_BASE:  base_offset    <= pwdata;
        REG_LIMIT: vertex_limit   <= pwdata;
        default:   ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      REG_MODE:  prdata = {30'd0, primitive_mode};
      REG_FLIP:  prdata = {31'd0, winding_swap};
      REG_BASE:  prdata = base_offset;
      REG_LIMIT: prdata = vertex_limit;
      default:   prdata = '0;
    endcase
  end

  // Only the low INDEX_WIDTH bits of the index take part.
  assign local_index  = VTX_W'(index_value[INDEX_WIDTH-1:0]);
  assign out_of_range = local_index >= vertex_limit;
  assign sum          = {1'b0, base_offset} + {1'b0, local_index};
  assign strip_or_fan = (primitive_mode == MODE_STRIP) || (primitive_mode == MODE_FAN);
  assign count        = strip_or_fan ? seen_count : list_phase;

  // Corner order: odd strip triangles swap the first two corners, then the
  // winding flip swaps the second and third.
  always_comb begin
    tri_a = held_older;
    tri_b = held_newer;
    if (primitive_mode == MODE_STRIP && strip_parity) begin
      tri_a = held_newer;
      tri_b = held_older;
    end
    tri_c = sum[VTX_W-1:0];
    if (winding_swap) begin
      tri_c = tri_b;
      tri_b = sum[VTX_W-1:0];
    end
  end

  // Next primitive state and the result of one word.
  always_comb begin
    held_older_next   = held_older;
    held_newer_next   = held_newer;
    list_phase_next   = list_phase;
    seen_count_next   = seen_count;
    strip_parity_next = strip_parity;
    aborted_next      = aborted;
    res_valid         = 1'b0;
    res_a             = '0;
    res_b             = '0;
    res_c             = '0;
    res_status        = ST_TRIANGLE;

    if (aborted) begin
      // Words are dropped until the end of the primitive.
    end else if (out_of_range || sum[VTX_W]) begin
      res_valid    = 1'b1;
      res_status   = out_of_range ? ST_RANGE : ST_OVERFLOW;
      aborted_next = 1'b1;
    end else begin
      if (count == CNT_NONE) begin
        held_older_next = sum[VTX_W-1:0];
      end else if (count == CNT_ONE) begin
        held_newer_next = sum[VTX_W-1:0];
      end else begin
        res_valid       = 1'b1;
        res_a           = tri_a;
        res_b           = tri_b;
        res_c           = tri_c;
        // Strip and fan keep the newest corner; a list starts over.
        if (strip_or_fan) begin
          held_newer_next = sum[VTX_W-1:0];
        end
        if (primitive_mode == MODE_STRIP) begin
          held_older_next   = held_newer;
          strip_parity_next = ~strip_parity;
        end
      end
      if (strip_or_fan) begin
        if (count != CNT_TWO) begin
          seen_count_next = count + 2'd1;
        end
      end else begin
        list_phase_next = (count == CNT_TWO) ? CNT_NONE : count + 2'd1;
      end
      // A short primitive ends with a count error.
      if (last_index && count != CNT_TWO) begin
        res_valid  = 1'b1;
        res_status = ST_COUNT;
      end
    end

    // Every last word closes the primitive.
    if (last_index) begin
      held_older_next   = '0;
      held_newer_next   = '0;
      list_phase_next   = CNT_NONE;
      seen_count_next   = CNT_NONE;
      strip_parity_next = 1'b0;
      aborted_next      = 1'b0;
    end
  end

  // Primitive state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_older   <= '0;
      held_newer   <= '0;
      list_phase   <= CNT_NONE;
      seen_count   <= CNT_NONE;
      strip_parity <= 1'b0;
      aborted      <= 1'b0;
    end else if (accept) begin
      held_older   <= held_older_next;
      held_newer   <= held_newer_next;
      list_phase   <= list_phase_next;
      seen_count   <= seen_count_next;
      strip_parity <= strip_parity_next;
      aborted      <= aborted_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept & res_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      corner_first  <= res_a;
      corner_second <= res_b;
      corner_third  <= res_c;
      result_status <= res_status;
    end
  end

  // Error words carry zero corners.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_status != ST_TRIANGLE |->
      corner_first == '0 && corner_second == '0 && corner_third == '0)
    else $error("error word with nonzero corners");

  // Corner counters never reach three.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    list_phase != 2'd3 && seen_count != 2'd3)
    else $error("corner counter out of range");

  // A last word always leaves a clean primitive state.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_index |=>
      !aborted && list_phase == CNT_NONE && seen_count == CNT_NONE && !strip_parity)
    else $error("primitive state not cleared at last word");

  // A dropped word in an aborted primitive never produces a result.
  a_abort_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && aborted |=> !out_valid)
    else $error("result produced while aborted");

endmodule
